@@ src/ccb_pkg.sv @@
// ----------------------------------------------------------------------------
// ccb_pkg: shared types and codes of the click driven circle builder
// Transaction payloads, command, result kind and construction mode codes.
// ----------------------------------------------------------------------------
package ccb_pkg;

  localparam int COORD_BITS = 24;

  localparam logic [1:0] CMD_MOVE   = 2'd0;
  localparam logic [1:0] CMD_PRESS  = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  localparam logic [1:0] KIND_PREVIEW = 2'd0;
  localparam logic [1:0] KIND_COMMIT  = 2'd1;
  localparam logic [1:0] KIND_CANCEL  = 2'd2;

  localparam logic [1:0] MODE_CENTER_RADIUS = 2'd0;
  localparam logic [1:0] MODE_CENTER_DIAM   = 2'd1;
  localparam logic [1:0] MODE_TWO_ENDS      = 2'd2;
  localparam logic [1:0] MODE_THREE_POINT   = 2'd3;

  typedef struct packed {
    logic [1:0]                   cmd;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
  } ccb_in_t;

  typedef struct packed {
    logic [1:0]                   result_kind;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic [COORD_BITS:0]          radius;
    logic                         collinear;
    logic                         out_of_range;
  } ccb_out_t;

endpackage

@@ src/click_driven_circle_builder.sv @@
// ----------------------------------------------------------------------------
// click_driven_circle_builder: circle construction from pointer transactions
// Move, press and cancel transactions arrive on the in_ channel; preview,
// committed and cancel results leave on the out_ channel. cfg_wr_en writes
// the construction mode and clears the pending points.
// Presses that only collect a point, and moves before enough points, give
// no result. A circle is built one bit or one digit per cycle: a shift-add
// multiplier, a restoring divider and a digit square root. A circle takes
// two products and a root in the center and diameter modes; in three-point
// mode twelve products, two quotients and a root are done one after
// another; collinear points end after the two determinant products and a
// center offset beyond the radius range after the second quotient.
// Only one transaction is in work at a time: in_stall is high from the cycle
// after acceptance of a building transaction until its result is loaded into
// the output register. A finished result waits in the output register while
// out_stall is high; the next transaction is still accepted, and only a
// second result waits for the first to leave.
// Reset (synchronous, active low) returns to mode 0 with no pending points
// and an empty output register.
// ----------------------------------------------------------------------------
module click_driven_circle_builder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ccb_pkg::ccb_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ccb_pkg::ccb_out_t  out_data,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data
);
  import ccb_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int DW   = CB + 1;
  localparam int SQW  = 2 * CB + 2;
  localparam int BW   = DW;
  localparam int PW   = SQW + BW;
  localparam int QW   = 3 * CB + 6;
  localparam int WW   = 3 * CB + 8;
  localparam int DVW  = 2 * CB + 4;
  localparam int SSW  = 2 * CB + 4;
  localparam int RTW  = CB + 2;
  localparam int RMW  = RTW + 3;
  localparam int CNTW = $clog2(QW + 1);

  localparam logic [1:0] STEP_FIRST  = 2'd0;
  localparam logic [1:0] STEP_SECOND = 2'd1;
  localparam logic [1:0] STEP_THIRD  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_MLD, S_MUL, S_MACC, S_CHK, S_DLD, S_DIV, S_DFIN,
    S_SQLD, S_SQRT, S_SFIN, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_DET1, OP_DET2, OP_SBX, OP_SBY, OP_SQX, OP_SQY,
    OP_NX1, OP_NX2, OP_NY1, OP_NY2, OP_UX, OP_UY
  } op_t;

  state_t                 state_r;
  op_t                    op_r;
  logic [1:0]             mode_r;
  logic [1:0]             step_r;
  logic                   out_valid_r;
  ccb_out_t               out_data_r;

  logic signed [CB-1:0]   fst_x_r, fst_y_r, sec_x_r, sec_y_r, cur_x_r, cur_y_r;
  logic [1:0]             kind_r;
  logic signed [CB-1:0]   ox_r, oy_r;
  logic [CB:0]            rad_r;
  logic                   col_r, oor_r, big_r, dsel_r, dneg_r;

  logic signed [WW-1:0]   det_r, sumb_r, sumq_r, nx_r, ny_r, rsq_r;
  logic [BW-1:0]          uxm_r, uym_r;

  logic [PW-1:0]          mc_r, acc_r;
  logic [BW-1:0]          mp_r;
  logic                   msign_r;
  logic [CNTW-1:0]        itc_r;

  logic [QW-1:0]          dq_r;
  logic [DVW-1:0]         rem_r, dvs_r;

  logic [SSW-1:0]         sv_r;
  logic [RTW-1:0]         rt_r;
  logic [RMW-1:0]         rm_r;

  function automatic logic [DW-1:0] mag_d(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  function automatic logic [WW-1:0] mag_w(input logic signed [WW-1:0] v);
    return v[WW-1] ? WW'(-v) : WW'(v);
  endfunction

  // Flag bit on top, clamped coordinate below.
  function automatic logic [CB:0] sat_c(input logic signed [WW-1:0] v);
    logic [WW-CB:0] top;
    top = v[WW-1:CB-1];
    if (top == '0 || top == '1) begin
      return {1'b0, v[CB-1:0]};
    end else if (v[WW-1]) begin
      return {1'b1, 1'b1, {(CB-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(CB-1){1'b1}}};
    end
  endfunction

  // Midpoint rounded half away from zero; always inside the coordinate range.
  function automatic logic [CB-1:0] mid_c(input logic signed [CB-1:0] a,
                                          input logic signed [CB-1:0] b);
    logic signed [DW-1:0] v;
    logic [DW-1:0]        m;
    v = $signed({a[CB-1], a}) + $signed({b[CB-1], b});
    m = (mag_d(v) + DW'(1)) >> 1;
    return v[DW-1] ? CB'(-m) : CB'(m);
  endfunction

  // Differences from the first point.
  logic signed [DW-1:0] bx, by, qx, qy;
  assign bx = $signed({sec_x_r[CB-1], sec_x_r}) - $signed({fst_x_r[CB-1], fst_x_r});
  assign by = $signed({sec_y_r[CB-1], sec_y_r}) - $signed({fst_y_r[CB-1], fst_y_r});
  assign qx = $signed({cur_x_r[CB-1], cur_x_r}) - $signed({fst_x_r[CB-1], fst_x_r});
  assign qy = $signed({cur_y_r[CB-1], cur_y_r}) - $signed({fst_y_r[CB-1], fst_y_r});

  // Operand selection for the shared multiplier.
  logic [SQW-1:0] opa;
  logic [BW-1:0]  opb;
  logic           opa_s, opb_s, op_sub;
  logic signed [WW-1:0] macc_old, macc_val, prod_s;

  always_comb begin
    opa      = '0;
    opb      = '0;
    opa_s    = 1'b0;
    opb_s    = 1'b0;
    op_sub   = 1'b0;
    macc_old = '0;
    case (op_r)
      OP_DET1: begin
        opa = SQW'(mag_d(bx)); opa_s = bx[DW-1]; opb = mag_d(qy); opb_s = qy[DW-1];
        macc_old = det_r;
      end
      OP_DET2: begin
        opa = SQW'(mag_d(by)); opa_s = by[DW-1]; opb = mag_d(qx); opb_s = qx[DW-1];
        op_sub = 1'b1; macc_old = det_r;
      end
      OP_SBX: begin
        opa = SQW'(mag_d(bx)); opb = mag_d(bx); macc_old = sumb_r;
      end
      OP_SBY: begin
        opa = SQW'(mag_d(by)); opb = mag_d(by); macc_old = sumb_r;
      end
      OP_SQX: begin
        opa = SQW'(mag_d(qx)); opb = mag_d(qx); macc_old = sumq_r;
      end
      OP_SQY: begin
        opa = SQW'(mag_d(qy)); opb = mag_d(qy); macc_old = sumq_r;
      end
      OP_NX1: begin
        opa = sumb_r[SQW-1:0]; opb = mag_d(qy); opb_s = qy[DW-1]; macc_old = nx_r;
      end
      OP_NX2: begin
        opa = sumq_r[SQW-1:0]; opb = mag_d(by); opb_s = by[DW-1];
        op_sub = 1'b1; macc_old = nx_r;
      end
      OP_NY1: begin
        opa = sumq_r[SQW-1:0]; opb = mag_d(bx); opb_s = bx[DW-1]; macc_old = ny_r;
      end
      OP_NY2: begin
        opa = sumb_r[SQW-1:0]; opb = mag_d(qx); opb_s = qx[DW-1];
        op_sub = 1'b1; macc_old = ny_r;
      end
      OP_UX: begin
        opa = SQW'(uxm_r); opb = uxm_r; macc_old = rsq_r;
      end
      OP_UY: begin
        opa = SQW'(uym_r); opb = uym_r; macc_old = rsq_r;
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  assign prod_s   = msign_r ? -$signed(WW'(acc_r)) : $signed(WW'(acc_r));
  assign macc_val = op_sub ? macc_old - prod_s : macc_old + prod_s;

  // Shift-add multiplier step.
  logic [PW-1:0] acc_nxt;
  assign acc_nxt = mp_r[0] ? acc_r + mc_r : acc_r;

  // Divider: |n| + |det| over 2|det| gives the quotient rounded half away.
  logic signed [WW-1:0] nsel;
  logic [WW-1:0]        an, adet;
  logic [QW-1:0]        dvd_ld;
  logic [DVW-1:0]       dvs_ld;
  logic [DVW:0]         remt;
  logic                 dge;
  logic [DVW-1:0]       rem_nxt;
  logic [QW-1:0]        dq_nxt;

  assign nsel    = dsel_r ? ny_r : nx_r;
  assign an      = mag_w(nsel);
  assign adet    = mag_w(det_r);
  assign dvd_ld  = QW'(an + adet);
  assign dvs_ld  = {adet[DVW-2:0], 1'b0};
  assign remt    = {rem_r, dq_r[QW-1]};
  assign dge     = remt >= {1'b0, dvs_r};
  assign rem_nxt = dge ? DVW'(remt - {1'b0, dvs_r}) : DVW'(remt);
  assign dq_nxt  = {dq_r[QW-2:0], dge};

  // Quotient to center coordinate.
  logic signed [WW-1:0] uq, fsel, csum;
  logic [CB:0]          csat;
  logic                 qbig;
  assign uq   = dneg_r ? -$signed(WW'(dq_r)) : $signed(WW'(dq_r));
  assign fsel = dsel_r ? WW'(fst_y_r) : WW'(fst_x_r);
  assign csum = fsel + uq;
  assign csat = sat_c(csum);
  assign qbig = |dq_r[QW-1:BW];

  // Digit square root step, two radicand bits per cycle.
  logic [RMW-1:0] remt_s, trial;
  logic           sge;
  logic [RMW-1:0] rm_nxt;
  logic [RTW-1:0] rt_nxt;
  logic [SSW-1:0] sv_nxt;
  assign remt_s = {rm_r[RMW-3:0], sv_r[SSW-1:SSW-2]};
  assign trial  = {1'b0, rt_r, 2'b01};
  assign sge    = remt_s >= trial;
  assign rm_nxt = sge ? remt_s - trial : remt_s;
  assign rt_nxt = {rt_r[RTW-2:0], sge};
  assign sv_nxt = {sv_r[SSW-3:0], 2'b00};

  logic [RTW:0] rad_rnd, rad_half, rad_sel;
  logic         rad_big;
  assign rad_rnd  = (RTW+1)'(rt_r) + (RTW+1)'(rm_r > RMW'(rt_r));
  assign rad_half = ((RTW+1)'(rt_r) + (RTW+1)'(1)) >> 1;
  assign rad_sel  = (mode_r == MODE_CENTER_RADIUS || mode_r == MODE_THREE_POINT) ?
                    rad_rnd : rad_half;
  assign rad_big  = |rad_sel[RTW:CB+1];

  logic [1:0] last_step;
  assign last_step = (mode_r == MODE_THREE_POINT) ? STEP_THIRD : STEP_SECOND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_FIRST;
      mode_r      <= MODE_CENTER_RADIUS;
      out_valid_r <= 1'b0;
    end else begin
      // The wait state reloads the output register itself.
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            case (in_data.cmd)
              CMD_CANCEL: begin
                if (step_r != STEP_FIRST) begin
                  step_r  <= STEP_FIRST;
                  kind_r  <= KIND_CANCEL;
                  ox_r    <= '0;
                  oy_r    <= '0;
                  rad_r   <= '0;
                  col_r   <= 1'b0;
                  oor_r   <= 1'b0;
                  state_r <= S_OUT;
                end
              end
              CMD_MOVE, CMD_PRESS: begin
                if (in_data.cmd == CMD_PRESS && step_r == STEP_FIRST) begin
                  fst_x_r <= in_data.point_x;
                  fst_y_r <= in_data.point_y;
                  step_r  <= STEP_SECOND;
                end else if (in_data.cmd == CMD_PRESS && step_r < last_step) begin
                  sec_x_r <= in_data.point_x;
                  sec_y_r <= in_data.point_y;
                  step_r  <= STEP_THIRD;
                end else if (step_r == last_step) begin
                  // Start building a circle through the current point.
                  cur_x_r <= in_data.point_x;
                  cur_y_r <= in_data.point_y;
                  kind_r  <= (in_data.cmd == CMD_PRESS) ? KIND_COMMIT : KIND_PREVIEW;
                  col_r   <= 1'b0;
                  oor_r   <= 1'b0;
                  det_r   <= '0;
                  sumb_r  <= '0;
                  sumq_r  <= '0;
                  nx_r    <= '0;
                  ny_r    <= '0;
                  rsq_r   <= '0;
                  if (mode_r == MODE_TWO_ENDS) begin
                    ox_r <= mid_c(fst_x_r, in_data.point_x);
                    oy_r <= mid_c(fst_y_r, in_data.point_y);
                  end else begin
                    ox_r <= fst_x_r;
                    oy_r <= fst_y_r;
                  end
                  op_r    <= (mode_r == MODE_THREE_POINT) ? OP_DET1 : OP_SQX;
                  state_r <= S_MLD;
                  if (in_data.cmd == CMD_PRESS) begin
                    step_r <= STEP_FIRST;
                  end
                end else if (in_data.cmd == CMD_PRESS) begin
                  step_r <= STEP_FIRST;
                end
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_MLD: begin
          mc_r    <= PW'(opa);
          mp_r    <= opb;
          msign_r <= opa_s ^ opb_s;
          acc_r   <= '0;
          itc_r   <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          acc_r <= acc_nxt;
          mc_r  <= mc_r << 1;
          mp_r  <= mp_r >> 1;
          itc_r <= itc_r + CNTW'(1);
          if (itc_r == CNTW'(BW - 1)) begin
            state_r <= S_MACC;
          end
        end
        S_MACC: begin
          state_r <= S_MLD;
          case (op_r)
            OP_DET1: begin det_r <= macc_val; op_r <= OP_DET2; end
            OP_DET2: begin det_r <= macc_val; state_r <= S_CHK; end
            OP_SBX:  begin sumb_r <= macc_val; op_r <= OP_SBY; end
            OP_SBY:  begin sumb_r <= macc_val; op_r <= OP_SQX; end
            OP_SQX:  begin sumq_r <= macc_val; op_r <= OP_SQY; end
            OP_SQY: begin
              sumq_r <= macc_val;
              if (mode_r == MODE_THREE_POINT) begin
                op_r <= OP_NX1;
              end else begin
                state_r <= S_SQLD;
              end
            end
            OP_NX1:  begin nx_r <= macc_val; op_r <= OP_NX2; end
            OP_NX2:  begin nx_r <= macc_val; op_r <= OP_NY1; end
            OP_NY1:  begin ny_r <= macc_val; op_r <= OP_NY2; end
            OP_NY2: begin
              ny_r    <= macc_val;
              dsel_r  <= 1'b0;
              state_r <= S_DLD;
            end
            OP_UX:   begin rsq_r <= macc_val; op_r <= OP_UY; end
            OP_UY:   begin rsq_r <= macc_val; state_r <= S_SQLD; end
            default: begin state_r <= S_IDLE; end
          endcase
        end
        S_CHK: begin
          if (det_r == '0) begin
            // Collinear points: no circle exists.
            col_r   <= 1'b1;
            ox_r    <= '0;
            oy_r    <= '0;
            rad_r   <= '0;
            state_r <= S_OUT;
          end else begin
            op_r    <= OP_SBX;
            state_r <= S_MLD;
          end
        end
        S_DLD: begin
          dq_r    <= dvd_ld;
          dvs_r   <= dvs_ld;
          rem_r   <= '0;
          dneg_r  <= nsel[WW-1] ^ det_r[WW-1];
          itc_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          dq_r  <= dq_nxt;
          rem_r <= rem_nxt;
          itc_r <= itc_r + CNTW'(1);
          if (itc_r == CNTW'(QW - 1)) begin
            state_r <= S_DFIN;
          end
        end
        S_DFIN: begin
          if (!dsel_r) begin
            ox_r    <= csat[CB-1:0];
            oor_r   <= oor_r | csat[CB];
            uxm_r   <= dq_r[BW-1:0];
            big_r   <= qbig;
            dsel_r  <= 1'b1;
            state_r <= S_DLD;
          end else begin
            oy_r  <= csat[CB-1:0];
            uym_r <= dq_r[BW-1:0];
            // A center offset this large saturates the radius outright.
            if (big_r || qbig) begin
              rad_r   <= '1;
              oor_r   <= 1'b1;
              state_r <= S_OUT;
            end else begin
              oor_r   <= oor_r | csat[CB];
              op_r    <= OP_UX;
              state_r <= S_MLD;
            end
          end
        end
        S_SQLD: begin
          sv_r    <= (mode_r == MODE_THREE_POINT) ? rsq_r[SSW-1:0] : sumq_r[SSW-1:0];
          rt_r    <= '0;
          rm_r    <= '0;
          itc_r   <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          sv_r  <= sv_nxt;
          rt_r  <= rt_nxt;
          rm_r  <= rm_nxt;
          itc_r <= itc_r + CNTW'(1);
          if (itc_r == CNTW'(RTW - 1)) begin
            state_r <= S_SFIN;
          end
        end
        S_SFIN: begin
          if (rad_big) begin
            rad_r <= '1;
            oor_r <= 1'b1;
          end else begin
            rad_r <= rad_sel[CB:0];
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.result_kind  <= kind_r;
            out_data_r.center_x     <= ox_r;
            out_data_r.center_y     <= oy_r;
            out_data_r.radius       <= rad_r;
            out_data_r.collinear    <= col_r;
            out_data_r.out_of_range <= oor_r;
            out_valid_r             <= 1'b1;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
        step_r <= STEP_FIRST;
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_third_step_only_in_three_point: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_THREE_POINT) |-> (step_r != STEP_THIRD && step_r <= STEP_THIRD))
    else $error("build step beyond the last point of the mode");

  a_result_waits_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && out_stall) |=> (state_r == S_OUT && out_valid_r))
    else $error("result left the wait state while the output register was full");

  a_collinear_gives_empty_circle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.collinear) |->
    (out_data_r.radius == '0 && !out_data_r.out_of_range && out_data_r.center_x == '0))
    else $error("collinear result carries a circle");

  a_cancel_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.result_kind == KIND_CANCEL) |->
    (out_data_r.radius == '0 && out_data_r.center_y == '0 && !out_data_r.collinear))
    else $error("cancel transaction carries circle data");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the click driven circle builder
// Drives move, press and cancel transactions in all four construction modes,
// predicts every preview, commit and cancel result with a bit-exact circle
// calculator, and compares the results field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  import ccb_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int    WATCHDOG_LIMIT = 30000;
  localparam int    SETTLE_CYCLES  = 700;
  localparam wide_t COORD_MAX      = (wide_t'(1) <<< (COORD_BITS - 1)) - 1;
  localparam wide_t COORD_MIN      = -(wide_t'(1) <<< (COORD_BITS - 1));
  localparam wide_t RADIUS_MAX     = (wide_t'(1) <<< (COORD_BITS + 1)) - 1;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ccb_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ccb_out_t out_data;
  logic     cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = '0;

  // Shadow state of the builder.
  logic [1:0] cur_mode = MODE_CENTER_RADIUS;
  int         pend_step = 0;
  wide_t      first_px = 0, first_py = 0, second_px = 0, second_py = 0;

  ccb_out_t circle_queue[$];
  int       fail_count = 0;
  int       idle_count = 0;
  bit       no_gaps = 1'b0;

  click_driven_circle_builder u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic wide_t abs_w(wide_t v);
    return v < 0 ? -v : v;
  endfunction

  // Quotient rounded half away from zero.
  function automatic wide_t round_div(wide_t n, wide_t d);
    wide_t q;
    q = (2 * abs_w(n) + abs_w(d)) / (2 * abs_w(d));
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic wide_t sqrt_floor(wide_t s);
    wide_t r, c;
    r = 0;
    for (int b = 47; b >= 0; b--) begin
      c = r | (wide_t'(1) <<< b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function automatic wide_t sqrt_nearest(wide_t s);
    wide_t r;
    r = sqrt_floor(s);
    if (r * r + r < s) r = r + 1;
    return r;
  endfunction

  function automatic wide_t clamp_coord(wide_t v, ref bit flag);
    if (v < COORD_MIN) begin
      flag = 1'b1;
      return COORD_MIN;
    end
    if (v > COORD_MAX) begin
      flag = 1'b1;
      return COORD_MAX;
    end
    return v;
  endfunction

  function automatic void add_expected(ccb_out_t r);
    circle_queue.insert(circle_queue.size(), r);
  endfunction

  function automatic ccb_out_t predict_circle(wide_t x, wide_t y, logic [1:0] kind);
    ccb_out_t res;
    wide_t cx, cy, r, dsq, bx, by, qx, qy, bsq, qsq, det, nx, ny, ux, uy;
    bit rbig, col, oor;
    cx = first_px;
    cy = first_py;
    r = 0;
    rbig = 0;
    col = 0;
    oor = 0;
    dsq = (x - first_px) * (x - first_px) + (y - first_py) * (y - first_py);
    case (cur_mode)
      MODE_CENTER_RADIUS: r = sqrt_nearest(dsq);
      MODE_CENTER_DIAM:   r = (sqrt_floor(dsq) + 1) >>> 1;
      MODE_TWO_ENDS: begin
        cx = round_div(first_px + x, 2);
        cy = round_div(first_py + y, 2);
        r  = (sqrt_floor(dsq) + 1) >>> 1;
      end
      default: begin
        bx = second_px - first_px;
        by = second_py - first_py;
        qx = x - first_px;
        qy = y - first_py;
        bsq = bx * bx + by * by;
        qsq = qx * qx + qy * qy;
        det = bx * qy - by * qx;
        if (det == 0) begin
          cx = 0;
          cy = 0;
          col = 1;
        end else begin
          nx = bsq * qy - qsq * by;
          ny = qsq * bx - bsq * qx;
          ux = round_div(nx, 2 * det);
          uy = round_div(ny, 2 * det);
          cx = first_px + ux;
          cy = first_py + uy;
          if (abs_w(ux) >= RADIUS_MAX + 1 || abs_w(uy) >= RADIUS_MAX + 1) rbig = 1;
          else r = sqrt_nearest(ux * ux + uy * uy);
        end
      end
    endcase
    cx = clamp_coord(cx, oor);
    cy = clamp_coord(cy, oor);
    if (rbig || r > RADIUS_MAX) begin
      r = RADIUS_MAX;
      oor = 1;
    end
    res.result_kind  = kind;
    res.center_x     = cx[COORD_BITS-1:0];
    res.center_y     = cy[COORD_BITS-1:0];
    res.radius       = r[COORD_BITS:0];
    res.collinear    = col;
    res.out_of_range = oor;
    return res;
  endfunction

  // Advance the shadow state for one accepted transaction.
  function automatic void track_transaction(ccb_in_t t);
    wide_t x, y;
    int last;
    x = wide_t'($signed(t.point_x));
    y = wide_t'($signed(t.point_y));
    last = (cur_mode == MODE_THREE_POINT) ? 2 : 1;
    case (t.cmd)
      CMD_CANCEL: begin
        if (pend_step != 0) begin
          pend_step = 0;
          add_expected('{result_kind: KIND_CANCEL, default: '0});
        end
      end
      CMD_MOVE: begin
        if (pend_step == last)
          add_expected(predict_circle(x, y, KIND_PREVIEW));
      end
      CMD_PRESS: begin
        if (pend_step == 0) begin
          first_px = x;
          first_py = y;
          pend_step = 1;
        end else if (pend_step < last) begin
          second_px = x;
          second_py = y;
          pend_step = 2;
        end else begin
          add_expected(predict_circle(x, y, KIND_COMMIT));
          pend_step = 0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_event(logic [1:0] cmd, logic [23:0] x, logic [23:0] y);
    ccb_in_t t;
    t = '{cmd: cmd, point_x: x, point_y: y};
    while (!no_gaps && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    track_transaction(t);
  endtask

  // Drain all results, let a silent build finish, then load a new mode.
  task automatic load_mode(logic [1:0] mode);
    in_valid <= 1'b0;
    @(posedge clk);
    while (circle_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_mode  = mode;
    pend_step = 0;
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2, 3, 4: return 24'($signed($urandom_range(0, 4000)) - 2000);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_center_radius();
    load_mode(MODE_CENTER_RADIUS);
    send_event(CMD_CANCEL, 24'd0, 24'd0);
    send_event(CMD_MOVE, 24'd5, 24'd5);
    send_event(CMD_PRESS, 24'd0, 24'd0);
    send_event(CMD_MOVE, 24'h7FFFFF, 24'h7FFFFF);
    send_event(CMD_MOVE, 24'd3, 24'd4);
    send_event(2'd3, 24'd1, 24'd1);
    send_event(CMD_PRESS, 24'h800000, 24'h800000);
    send_event(CMD_PRESS, 24'h7FFFFF, 24'h800000);
    send_event(CMD_PRESS, 24'h800000, 24'h7FFFFF);
    send_event(CMD_PRESS, 24'd100, 24'd100);
    send_event(CMD_CANCEL, 24'hFFFFFF, 24'hFFFFFF);
  endtask

  task automatic test_center_diameter();
    load_mode(MODE_CENTER_DIAM);
    send_event(CMD_PRESS, 24'h800000, 24'h800000);
    send_event(CMD_MOVE, 24'h7FFFFF, 24'h7FFFFF);
    send_event(CMD_PRESS, 24'd3, 24'd0);
  endtask

  task automatic test_two_ends();
    load_mode(MODE_TWO_ENDS);
    send_event(CMD_PRESS, 24'hFFFFFF, 24'hFFFFFD);
    send_event(CMD_MOVE, 24'd0, 24'd0);
    send_event(CMD_PRESS, 24'h800000, 24'h7FFFFF);
  endtask

  task automatic test_three_point();
    load_mode(MODE_THREE_POINT);
    send_event(CMD_PRESS, 24'd0, 24'd0);
    send_event(CMD_PRESS, 24'd1000, 24'd0);
    send_event(CMD_MOVE, 24'd0, 24'd1000);
    send_event(CMD_MOVE, 24'd2000, 24'd0);
    send_event(CMD_PRESS, 24'd500, 24'd333);
    // Nearly collinear far points push the center out of range.
    send_event(CMD_PRESS, 24'h800000, 24'h800000);
    send_event(CMD_PRESS, 24'h7FFFFF, 24'h7FFFFF);
    send_event(CMD_PRESS, 24'h7FFFFE, 24'h7FFFFF);
    send_event(CMD_PRESS, 24'd5, 24'd5);
    send_event(CMD_CANCEL, 24'd0, 24'd0);
  endtask

  task automatic test_random_sequences(int total);
    int sent, mode_left, last;
    logic [23:0] x, y;
    sent = 0;
    mode_left = 0;
    while (sent < total) begin
      no_gaps = (sent > total / 2 && sent < total / 2 + 200);
      if (mode_left == 0) begin
        load_mode(2'($urandom_range(0, 3)));
        mode_left = $urandom_range(60, 200);
      end
      last = (cur_mode == MODE_THREE_POINT) ? 2 : 1;
      if ($urandom_range(0, 9) == 0) begin
        // Noise: any command, including the unused code.
        send_event(2'($urandom), rand_coord(), rand_coord());
        sent++;
        mode_left--;
      end else begin
        for (int k = 0; k <= last; k++) begin
          repeat ($urandom_range(0, 3)) begin
            if (k == last || $urandom_range(0, 3) == 0) begin
              send_event(CMD_MOVE, rand_coord(), rand_coord());
              sent++;
            end
          end
          if (k == last && $urandom_range(0, 11) == 0) begin
            send_event(CMD_CANCEL, rand_coord(), rand_coord());
          end else if (k == 2 && $urandom_range(0, 7) == 0) begin
            // Third point on the line through the first two.
            x = 24'(2 * second_px - first_px);
            y = 24'(2 * second_py - first_py);
            send_event(CMD_PRESS, x, y);
          end else begin
            send_event(CMD_PRESS, rand_coord(), rand_coord());
          end
          sent++;
        end
        mode_left = (mode_left > last + 1) ? mode_left - last - 1 : 0;
      end
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(0, 99) < 26);
  end

  always @(posedge clk) begin
    ccb_out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (circle_queue.size() == 0) begin
        $error("unexpected result transaction %h", out_data);
        fail_count++;
      end else begin
        exp_res = circle_queue.pop_front();
        if (out_data.result_kind !== exp_res.result_kind) begin
          $error("result_kind expected %0d actual %0d", exp_res.result_kind,
                 out_data.result_kind);
          fail_count++;
        end
        if (out_data.center_x !== exp_res.center_x) begin
          $error("center_x expected %0d actual %0d", exp_res.center_x, out_data.center_x);
          fail_count++;
        end
        if (out_data.center_y !== exp_res.center_y) begin
          $error("center_y expected %0d actual %0d", exp_res.center_y, out_data.center_y);
          fail_count++;
        end
        if (out_data.radius !== exp_res.radius) begin
          $error("radius expected %0d actual %0d", exp_res.radius, out_data.radius);
          fail_count++;
        end
        if (out_data.collinear !== exp_res.collinear) begin
          $error("collinear expected %0d actual %0d", exp_res.collinear,
                 out_data.collinear);
          fail_count++;
        end
        if (out_data.out_of_range !== exp_res.out_of_range) begin
          $error("out_of_range expected %0d actual %0d", exp_res.out_of_range,
                 out_data.out_of_range);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_center_radius();
    test_center_diameter();
    test_two_ends();
    test_three_point();
    load_mode(MODE_THREE_POINT);
    test_random_sequences(1520);
    in_valid <= 1'b0;
    @(posedge clk);
    while (circle_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
